// ----- hw/rtl/vlbs_pkg.sv -----
package vlbs_pkg;

    localparam int MAX_LINE_WIDTH   = 16384;
    localparam int WINDOW           = 121;
    localparam int HALF_WINDOW      = WINDOW / 2;

    localparam int CFG_W            = 15;
    localparam int LINE_WIDTH_RESET = 13680;
    localparam int PIX_W            = 8;
    localparam int SUM_W            = 15;

    // Column index, effective width, ring row and line counter widths.
    localparam int CW  = $clog2(MAX_LINE_WIDTH);
    localparam int WW  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int RW  = $clog2(WINDOW);
    localparam int LRW = $clog2(WINDOW + 1);

    localparam int RING_DEPTH = WINDOW * MAX_LINE_WIDTH;
    localparam int RA         = $clog2(RING_DEPTH);

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

    // Division by WINDOW as a multiply by a rounded-up reciprocal. The shift leaves
    // an error below one over WINDOW for every sum that fits in SUM_W bits.
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MUL_W     = $clog2(DIV_MUL + 1);
    localparam int PROD_W    = SUM_W + MUL_W;

    typedef enum logic [1:0] {
        ACT_PIXEL     = 2'd0,
        ACT_FLUSH     = 2'd1,
        ACT_NEW_FRAME = 2'd2
    } t_action;

    typedef struct packed {
        t_action            action;
        logic [PIX_W-1:0]   pixel;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic               smoothed;
        logic               end_of_line;
    } t_out_word;

    // One accepted item after address generation, ready for the memory stage.
    typedef struct packed {
        logic               valid;
        logic               is_pixel;
        logic [PIX_W-1:0]   pixel;
        logic [CW-1:0]      col;
        logic [RA-1:0]      ring_rd_addr;
        logic [RA-1:0]      ring_wr_addr;
        logic               use_sum;
        logic               subtract;
        logic               has_result;
        logic               smoothed;
        logic               eol;
    } t_issue;

    // Result of the memory stage, before the average is formed.
    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   full;
        logic [PIX_W-1:0]   raw;
        logic               smoothed;
        logic               eol;
    } t_calc;

endpackage

// ----- hw/rtl/vertical_line_boxcar_smoother_unit.sv -----
// Vertical boxcar smoother. Pixels enter in raster order on the input channel
// (i_in_valid, o_in_stall, i_in_word); each word carries a pixel, a flush request
// or a new-frame marker. Output words (o_out_valid, i_out_stall, o_out_word)
// carry the pixel WINDOW/2 lines above, averaged over its WINDOW-line column
// window or passed raw at the head and tail of a frame. Flush words drain the
// pending tail lines, one pixel each. The line width register is written over
// i_cfg_valid / i_cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. o_cfg_ready is always high.
// Throughput is one word per clock while o_in_stall is low, set by the single
// read-modify-write of the line ring and the column sum memory per pixel. A
// result passes through the memory read, the sum and subtract, then the
// reciprocal multiply into a four-word output queue.
// When the receiver stalls the queue fills and o_in_stall rises once the queue
// and the words in flight could use up its space; nothing is lost.
// Reset clears counters, queue and pipeline valids and loads the default line
// width. The line ring and column sum memories are not cleared; every entry is
// written before it is used, so no clearing pass is needed.
module vertical_line_boxcar_smoother_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vlbs_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vlbs_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vlbs_pkg::t_out_word         o_out_word
);
    import vlbs_pkg::*;

    t_issue           issue;
    t_calc            calc;
    logic             s1_busy;
    logic [LVL_W-1:0] out_level;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (int'(out_level) + int'(s1_busy)) >= OUT_DEPTH;
    assign accept      = i_in_valid && !o_in_stall;

    vlbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_issue     (issue)
    );

    vlbs_mem_stage u_mem_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (issue),
        .o_calc  (calc),
        .o_busy  (s1_busy)
    );

    vlbs_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_calc      (calc),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_level     (out_level)
    );

endmodule

// ----- hw/rtl/vlbs_ctrl.sv -----
module vlbs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_write,
    input  logic [vlbs_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_accept,
    input  vlbs_pkg::t_in_word          i_word,
    output vlbs_pkg::t_issue            o_issue
);
    import vlbs_pkg::*;

    logic [CFG_W-1:0] r_line_width;
    logic [CW-1:0]    r_col,            n_col;
    logic [RW-1:0]    r_ring_row,       n_ring_row;
    logic [LRW-1:0]   r_lines_received, n_lines_received;
    logic [RW-1:0]    r_flush_row,      n_flush_row;
    logic [CW-1:0]    r_flush_col,      n_flush_col;
    logic [LRW-1:0]   r_lines_pending,  n_lines_pending;

    logic [WW-1:0]    eff_width;
    logic             eol_pixel;
    logic             eol_flush;
    logic             win_full;
    logic [RW-1:0]    rd_row;
    logic [RW-1:0]    next_row;
    logic [LRW-1:0]   lines_inc;
    logic [LRW-1:0]   pend_new;

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] row);
        return (row == RW'(WINDOW - 1)) ? '0 : row + RW'(1);
    endfunction

    function automatic logic [RW-1:0] row_sub(input logic [RW-1:0] row,
                                              input logic [LRW-1:0] n);
        int t;
        t = int'(row) - int'(n);
        if (t < 0) begin
            t = t + WINDOW;
        end
        return RW'(t);
    endfunction

    function automatic logic [RA-1:0] ring_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return RA'(row) * RA'(MAX_LINE_WIDTH) + RA'(col);
    endfunction

    always_comb begin
        if (r_line_width == '0) begin
            eff_width = WW'(1);
        end else if (int'(r_line_width) > MAX_LINE_WIDTH) begin
            eff_width = WW'(MAX_LINE_WIDTH);
        end else begin
            eff_width = WW'(r_line_width);
        end
    end

    assign eol_pixel = (WW'(r_col) + WW'(1)) >= eff_width;
    assign eol_flush = (WW'(r_flush_col) + WW'(1)) >= eff_width;
    assign win_full  = r_lines_received >= LRW'(WINDOW - 1);
    assign next_row  = row_inc(r_ring_row);
    assign lines_inc = (r_lines_received < LRW'(WINDOW)) ? r_lines_received + LRW'(1)
                                                         : r_lines_received;
    assign pend_new  = (lines_inc < LRW'(HALF_WINDOW)) ? lines_inc : LRW'(HALF_WINDOW);
    // Once the window is full the oldest line is read for subtraction; before that
    // the center line is read for raw output.
    assign rd_row    = win_full ? next_row : row_sub(r_ring_row, LRW'(HALF_WINDOW));

    always_comb begin
        n_col            = r_col;
        n_ring_row       = r_ring_row;
        n_lines_received = r_lines_received;
        n_flush_row      = r_flush_row;
        n_flush_col      = r_flush_col;
        n_lines_pending  = r_lines_pending;
        o_issue          = '0;

        if (i_accept) begin
            unique case (i_word.action)
                ACT_PIXEL: begin
                    o_issue.valid        = 1'b1;
                    o_issue.is_pixel     = 1'b1;
                    o_issue.pixel        = i_word.pixel;
                    o_issue.col          = r_col;
                    o_issue.ring_rd_addr = ring_addr(rd_row, r_col);
                    o_issue.ring_wr_addr = ring_addr(r_ring_row, r_col);
                    o_issue.use_sum      = (r_lines_received != '0);
                    o_issue.subtract     = win_full;
                    o_issue.has_result   = r_lines_received >= LRW'(HALF_WINDOW);
                    o_issue.smoothed     = win_full;
                    o_issue.eol          = eol_pixel;

                    if (r_lines_received == '0 && r_col == '0) begin
                        n_lines_pending = '0;
                        n_flush_col     = '0;
                    end
                    if (eol_pixel) begin
                        n_col            = '0;
                        n_ring_row       = next_row;
                        n_lines_received = lines_inc;
                        n_lines_pending  = pend_new;
                        n_flush_row      = row_sub(next_row, pend_new);
                        n_flush_col      = '0;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
                ACT_FLUSH: begin
                    n_lines_received = '0;
                    n_col            = '0;
                    if (r_lines_pending != '0) begin
                        o_issue.valid        = 1'b1;
                        o_issue.col          = r_flush_col;
                        o_issue.ring_rd_addr = ring_addr(r_flush_row, r_flush_col);
                        o_issue.has_result   = 1'b1;
                        o_issue.eol          = eol_flush;
                        if (eol_flush) begin
                            n_flush_col     = '0;
                            n_flush_row     = row_inc(r_flush_row);
                            n_lines_pending = r_lines_pending - LRW'(1);
                        end else begin
                            n_flush_col = r_flush_col + CW'(1);
                        end
                    end
                end
                ACT_NEW_FRAME: begin
                    n_col            = '0;
                    n_ring_row       = '0;
                    n_lines_received = '0;
                    n_flush_row      = '0;
                    n_flush_col      = '0;
                    n_lines_pending  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width     <= CFG_W'(LINE_WIDTH_RESET);
            r_col            <= '0;
            r_ring_row       <= '0;
            r_lines_received <= '0;
            r_flush_row      <= '0;
            r_flush_col      <= '0;
            r_lines_pending  <= '0;
        end else begin
            if (i_cfg_write) begin
                r_line_width <= i_cfg_data;
            end
            r_col            <= n_col;
            r_ring_row       <= n_ring_row;
            r_lines_received <= n_lines_received;
            r_flush_row      <= n_flush_row;
            r_flush_col      <= n_flush_col;
            r_lines_pending  <= n_lines_pending;
        end
    end

`ifndef ASSERT_OFF
    a_flush_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.action == ACT_FLUSH) |=> (r_lines_received == '0))
        else $error("flush did not end the frame");

    a_eol_wraps_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_issue.valid && o_issue.is_pixel && o_issue.eol) |=> (r_col == '0))
        else $error("column did not wrap at end of line");

    a_rows_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring_row < RW'(WINDOW)) && (r_flush_row < RW'(WINDOW))
        && (r_lines_pending <= LRW'(HALF_WINDOW)))
        else $error("ring row or pending line count out of range");
`endif

endmodule

// ----- hw/rtl/vlbs_mem_stage.sv -----
module vlbs_mem_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vlbs_pkg::t_issue    i_issue,
    output vlbs_pkg::t_calc     o_calc,
    output logic                o_busy
);
    import vlbs_pkg::*;

    logic [PIX_W-1:0] r_ring [RING_DEPTH];
    logic [SUM_W-1:0] r_sums [MAX_LINE_WIDTH];

    t_issue           r_s1;
    logic [PIX_W-1:0] r_ring_q;
    logic [SUM_W-1:0] r_sum_q;
    logic             r_ring_hit;
    logic [PIX_W-1:0] r_ring_fwd;
    logic             r_sum_hit;
    logic [SUM_W-1:0] r_sum_fwd;

    logic             s1_write;
    logic [PIX_W-1:0] ring_rd;
    logic [SUM_W-1:0] sum_rd;
    logic [SUM_W-1:0] full;
    logic [SUM_W-1:0] new_sum;

    assign s1_write = r_s1.valid && r_s1.is_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_ring[r_s1.ring_wr_addr] <= r_s1.pixel;
        end
        r_ring_q <= r_ring[i_issue.ring_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_sums[r_s1.col] <= new_sum;
        end
        r_sum_q <= r_sums[i_issue.col];
    end

    // The word in this stage writes at the same edge the next word reads, so a
    // read of the entry being written takes the new data from here.
    always_ff @(posedge i_clk) begin
        r_ring_hit <= s1_write && (i_issue.ring_rd_addr == r_s1.ring_wr_addr);
        r_ring_fwd <= r_s1.pixel;
        r_sum_hit  <= s1_write && (i_issue.col == r_s1.col);
        r_sum_fwd  <= new_sum;
    end

    assign ring_rd = r_ring_hit ? r_ring_fwd : r_ring_q;
    assign sum_rd  = r_sum_hit ? r_sum_fwd : r_sum_q;
    assign full    = r_s1.use_sum ? sum_rd + SUM_W'(r_s1.pixel) : SUM_W'(r_s1.pixel);
    assign new_sum = r_s1.subtract ? full - SUM_W'(ring_rd) : full;

    always_comb begin
        o_calc.valid    = r_s1.valid && r_s1.has_result;
        o_calc.full     = full;
        o_calc.raw      = ring_rd;
        o_calc.smoothed = r_s1.smoothed;
        o_calc.eol      = r_s1.eol;
    end

    assign o_busy = r_s1.valid && r_s1.has_result;

endmodule

// ----- hw/rtl/vlbs_out_stage.sv -----
module vlbs_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vlbs_pkg::t_calc             i_calc,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output vlbs_pkg::t_out_word         o_out_word,
    output logic [vlbs_pkg::LVL_W-1:0]  o_level
);
    import vlbs_pkg::*;

    t_calc            r_s2;
    t_out_word        r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_count;

    logic [PROD_W-1:0] prod;
    t_out_word         push_word;
    logic              push;
    logic              pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_calc;
        end
    end

    assign prod = PROD_W'(r_s2.full) * PROD_W'(DIV_MUL);

    always_comb begin
        push_word.value       = r_s2.smoothed ? prod[DIV_SHIFT +: PIX_W] : r_s2.raw;
        push_word.smoothed    = r_s2.smoothed;
        push_word.end_of_line = r_s2.eol;
    end

    assign push = r_s2.valid;
    assign pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + LVL_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - LVL_W'(1);
            end
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_word  = r_fifo[r_rd_ptr];
    assign o_level     = r_count + LVL_W'(r_s2.valid);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_count < LVL_W'(OUT_DEPTH)))
        else $error("output queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("pushed word not presented");
`endif

endmodule

// ----- sim/vertical_line_boxcar_smoother_unit_tb.sv -----
module vertical_line_boxcar_smoother_unit_tb;
    import vlbs_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 400;
    localparam int          RANDOM_ITEMS  = 1100;
    localparam int          RUN_LIMIT     = 4000000;
    localparam int unsigned SUM_MASK      = (1 << SUM_W) - 1;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_WORD  = 2'd2
    } t_check;

    typedef struct packed {
        logic               is_cfg;
        logic [CFG_W-1:0]   cfg;
        logic [1:0]         act;
        logic [PIX_W-1:0]   pix;
        t_check             chk;
        t_out_word          res;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, 15'd0,     ACT_UNUSED,    8'hAA, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h55, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'hFF, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_NEW_FRAME, 8'h00, CHK_NONE,  '0},
        '{1'b1, 15'd0,     ACT_PIXEL,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'hFF, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_WORD,  '{8'hFF, 1'b0, 1'b1}},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h00, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h80, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_WORD,  '{8'h00, 1'b0, 1'b1}},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_WORD,  '{8'h80, 1'b0, 1'b1}},
        '{1'b0, 15'd0,     ACT_NEW_FRAME, 8'hFF, CHK_NONE,  '0},
        '{1'b1, 15'd32767, ACT_PIXEL,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h01, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_NEW_FRAME, 8'h00, CHK_NONE,  '0},
        '{1'b1, 15'd2,     ACT_PIXEL,     8'h00, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h55, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'hAA, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'h3C, CHK_MODEL, '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_WORD,  '{8'h55, 1'b0, 1'b0}},
        '{1'b0, 15'd0,     ACT_PIXEL,     8'hC3, CHK_NONE,  '0},
        '{1'b0, 15'd0,     ACT_FLUSH,     8'h00, CHK_NONE,  '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    t_in_word           in_word;
    logic               out_valid;
    logic               out_stall;
    t_out_word          out_word;

    // Predicted state of the smoother.
    logic [CFG_W-1:0]   width_reg;
    int unsigned        col_pos;
    int unsigned        ring_row;
    int unsigned        lines_seen;
    int unsigned        drain_row;
    int unsigned        drain_col;
    int unsigned        lines_left;
    logic [PIX_W-1:0]   ring_mem [int];
    logic [SUM_W-1:0]   col_sum [MAX_LINE_WIDTH];

    t_out_word          due_words [$];
    int                 errors;
    int                 items_sent;
    bit                 in_idle_on;
    bit                 out_idle_on;
    int                 long_hold_asks;

    vertical_line_boxcar_smoother_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned eff_width();
        int unsigned v;
        v = int'(width_reg);
        if (v == 0) return 1;
        if (v > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
        return v;
    endfunction

    function automatic int unsigned ring_at(int unsigned row, int unsigned col);
        int key;
        key = int'(row * MAX_LINE_WIDTH + col);
        return ring_mem.exists(key) ? int'(ring_mem[key]) : 0;
    endfunction

    function automatic void restart_frame();
        col_pos    = 0;
        ring_row   = 0;
        lines_seen = 0;
        drain_row  = 0;
        drain_col  = 0;
        lines_left = 0;
    endfunction

    // Advances the predicted state by one word; returns 1 when it yields an output word.
    function automatic bit smooth_column(input t_in_word w, output t_out_word r);
        int unsigned wd;
        int unsigned c;
        int unsigned pix;
        int unsigned full;
        bit          eol;
        bit          has;
        has = 1'b0;
        r   = '0;
        wd  = eff_width();
        pix = int'(w.pixel);
        case (w.action)
            ACT_PIXEL: begin
                c = col_pos;
                if (lines_seen == 0 && col_pos == 0) begin
                    lines_left = 0;
                    drain_col  = 0;
                end
                eol  = (col_pos + 1 >= wd);
                full = (lines_seen == 0) ? pix : ((int'(col_sum[c]) + pix) & SUM_MASK);
                if (lines_seen >= HALF_WINDOW) begin
                    has = 1'b1;
                    if (lines_seen >= WINDOW - 1) begin
                        r.value    = PIX_W'(full / WINDOW);
                        r.smoothed = 1'b1;
                    end else begin
                        r.value    = PIX_W'(ring_at((ring_row + WINDOW - HALF_WINDOW) % WINDOW, c));
                        r.smoothed = 1'b0;
                    end
                    r.end_of_line = eol;
                end
                // Once the window is full the oldest line leaves the running sum.
                if (lines_seen >= WINDOW - 1) begin
                    full = (full - ring_at((ring_row + 1) % WINDOW, c)) & SUM_MASK;
                end
                col_sum[c] = SUM_W'(full);
                ring_mem[int'(ring_row * MAX_LINE_WIDTH + c)] = w.pixel;
                if (eol) begin
                    col_pos  = 0;
                    ring_row = (ring_row + 1) % WINDOW;
                    if (lines_seen < WINDOW) lines_seen++;
                    lines_left = (lines_seen < HALF_WINDOW) ? lines_seen : HALF_WINDOW;
                    drain_row  = (ring_row + WINDOW - lines_left) % WINDOW;
                    drain_col  = 0;
                end else begin
                    col_pos++;
                end
            end
            ACT_FLUSH: begin
                lines_seen = 0;
                col_pos    = 0;
                if (lines_left != 0) begin
                    has           = 1'b1;
                    eol           = (drain_col + 1 >= wd);
                    r.value       = PIX_W'(ring_at(drain_row, drain_col));
                    r.smoothed    = 1'b0;
                    r.end_of_line = eol;
                    if (eol) begin
                        drain_col = 0;
                        drain_row = (drain_row + 1) % WINDOW;
                        lines_left--;
                    end else begin
                        drain_col++;
                    end
                end
            end
            ACT_NEW_FRAME: begin
                restart_frame();
            end
            default: ;
        endcase
        return has;
    endfunction

    // Called and returns at a falling edge.
    task automatic push_word(input logic [1:0] act, input logic [PIX_W-1:0] pix,
                             input t_check chk, input t_out_word res);
        int        gap;
        t_in_word  w;
        t_out_word r;
        w   = t_in_word'({act, pix});
        gap = in_idle_on ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        if (smooth_column(w, r) && chk == CHK_MODEL) due_words.push_back(r);
        if (chk == CHK_WORD) due_words.push_back(res);
        if (act != ACT_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_random(input logic [1:0] act);
        push_word(act, PIX_W'($urandom_range(0, 255)), CHK_MODEL, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
        // A new-frame or ignored word may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        width_reg = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int idx);
        logic [CFG_W-1:0] wv;
        logic [PIX_W-1:0] pix;
        int unsigned      wd;
        int unsigned      lines;
        int unsigned      mode;
        int unsigned      sel;
        int unsigned      n;
        bit               pressure;
        pressure = (idx == 0);
        case (idx)
            0: wv = CFG_W'(1);
            1: wv = CFG_W'(MAX_LINE_WIDTH);
            2: wv = '0;
            3: wv = CFG_W'(MAX_LINE_WIDTH - 1);
            default: begin
                sel = $urandom_range(0, 19);
                if (sel < 10)      wv = CFG_W'(1);
                else if (sel < 16) wv = CFG_W'($urandom_range(2, 3));
                else if (sel < 19) wv = CFG_W'($urandom_range(4, 6));
                else               wv = CFG_W'($urandom_range(7, 32767));
            end
        endcase
        push_random(ACT_NEW_FRAME);
        write_width(wv);
        in_idle_on  = !pressure && ($urandom_range(0, 3) != 0);
        out_idle_on = pressure || ($urandom_range(0, 3) != 0);
        wd = eff_width();
        if (pressure)                     lines = 150;
        else if (wd == 1)                 lines = ($urandom_range(0, 5) == 0) ?
                                                  $urandom_range(1, 59) : $urandom_range(100, 170);
        else if (wd <= 3)                 lines = $urandom_range(50, 135);
        else if (wd <= 6)                 lines = $urandom_range(10, 70);
        else if (wd < 64)                 lines = $urandom_range(1, 8);
        else                              lines = 0;
        mode = $urandom_range(0, 3);
        n = 0;
        for (int unsigned ln = 0; ln < lines; ln++) begin
            for (int unsigned col = 0; col < wd; col++) begin
                if ($urandom_range(0, 199) == 0) push_random(ACT_UNUSED);
                if ($urandom_range(0, 399) == 0) push_random(ACT_FLUSH);
                if ($urandom_range(0, 599) == 0) push_random(ACT_NEW_FRAME);
                case (mode)
                    2:       pix = PIX_W'($urandom_range(240, 255));
                    3:       pix = PIX_W'($urandom_range(0, 15));
                    default: pix = PIX_W'($urandom_range(0, 255));
                endcase
                // Freeze the receiver once results are flowing, so the block backs up.
                if (pressure && n == 70) long_hold_asks++;
                push_word(ACT_PIXEL, pix, CHK_MODEL, '0);
                n++;
            end
        end
        // A partly received line is abandoned by the flush or new-frame word that follows.
        if (wd > 1 && (lines == 0 || $urandom_range(0, 2) == 0)) begin
            n = $urandom_range(1, (wd - 1 < 24) ? wd - 1 : 24);
            repeat (n) push_random(ACT_PIXEL);
        end
        if (lines_left != 0 && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, lines_left * wd);
            repeat (n) push_random(ACT_FLUSH);
        end else begin
            while (lines_left != 0) push_random(ACT_FLUSH);
        end
        repeat ($urandom_range(0, 2)) push_random(ACT_FLUSH);
    endtask

    initial begin : receiver
        int        hold_left;
        int        holds_done;
        t_out_word want;
        hold_left  = 0;
        holds_done = 0;
        out_stall  = 1'b0;
        errors     = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_asks != holds_done) begin
                holds_done = long_hold_asks;
                hold_left  = LONG_HOLD;
            end
            out_stall <= (hold_left > 0);
            if (hold_left > 0) hold_left--;
            @(posedge i_clk);
            if (i_rst_n && out_valid && !out_stall) begin
                if (due_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got value %0h smoothed %0b eol %0b",
                             $time, out_word.value, out_word.smoothed, out_word.end_of_line);
                end else begin
                    want = due_words.pop_front();
                    if (out_word.value !== want.value) begin
                        errors++;
                        $display("%0t: value mismatch, expected %0h, got %0h",
                                 $time, want.value, out_word.value);
                    end
                    if (out_word.smoothed !== want.smoothed) begin
                        errors++;
                        $display("%0t: smoothed mismatch, expected %0b, got %0b",
                                 $time, want.smoothed, out_word.smoothed);
                    end
                    if (out_word.end_of_line !== want.end_of_line) begin
                        errors++;
                        $display("%0t: end_of_line mismatch, expected %0b, got %0b",
                                 $time, want.end_of_line, out_word.end_of_line);
                    end
                end
                hold_left = out_idle_on ? int'($urandom_range(0, 15)) : 0;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int random_start;
        i_rst_n        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_word        = '0;
        items_sent     = 0;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        long_hold_asks = 0;
        width_reg      = CFG_W'(LINE_WIDTH_RESET);
        restart_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (SCRIPT[i].is_cfg) write_width(SCRIPT[i].cfg);
            else push_word(SCRIPT[i].act, SCRIPT[i].pix, SCRIPT[i].chk, SCRIPT[i].res);
        end

        random_start = items_sent;
        phase = 0;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        wait_drained();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
